### design/wrm_pkg.sv
// Package for the wildcard pattern stream matcher.
// Holds widths, character codes, register indexes and the per-item control struct.
// No dependencies.
package wrm_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int CHAR_SLOTS      = 16;
	localparam int LEN_W           = 5;
	localparam int CHAR_W          = 8;
	localparam int WORD_W          = 64;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CHAR_W-1:0] STAR_CODE = 8'h2A;
	localparam logic [CHAR_W-1:0] DOT_CODE  = 8'h2E;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LENGTH = 2'd0,
		CFG_CHARS_LOW      = 2'd1,
		CFG_CHARS_HIGH     = 2'd2
	} cfg_idx_t;

	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_APPEND = 1'b1;

	// Broadcast to every cell on each accepted transaction.
	typedef struct packed {
		logic              en;
		logic              load;
		logic [CHAR_W-1:0] ch;
	} step_t;

endpackage

### design/wrm_cell.sv
// One column cell of the matcher: holds the match bit of one pattern prefix.
// Depends on wrm_pkg.
module wrm_cell #(
	parameter int IDX = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wrm_pkg::step_t       step,
	input  logic [7:0]           p_cur,
	input  logic [7:0]           p_prev,
	input  logic                 old_prev,
	input  logic                 nxt_back2,
	output logic                 col_q,
	output logic                 nxt
);
	import wrm_pkg::*;

	localparam bit HAS_PREV = (IDX >= 2);

	logic cur_star;
	logic acc_cur;
	logic acc_prev;

	always_comb begin
		cur_star = (p_cur == STAR_CODE);
		acc_cur  = (p_cur == DOT_CODE) || (p_cur == step.ch);
		acc_prev = (p_prev == DOT_CODE) || (p_prev == step.ch);
		if (step.load) begin
			nxt = cur_star && HAS_PREV && nxt_back2;
		end else if (cur_star) begin
			// star: skip the pair, or absorb one more copy of the element
			nxt = HAS_PREV && (nxt_back2 || (col_q && acc_prev));
		end else begin
			nxt = old_prev && acc_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 1'b0;
		end else if (step.en) begin
			col_q <= nxt;
		end
	end

endmodule

### design/wildcard_regex_stream_match_top.sv
// Streaming '.'/'*' whole-text matcher, one cell per pattern prefix.
// Result valid in the cycle after input acceptance. Throughput: one item per cycle
// unless out_ready stalls; the cycle is set by the star ripple across the cell row.
// Reset (arst_n low): column clear, registers zero, no result pending.
// Depends on wrm_pkg and wrm_cell.
module wildcard_regex_stream_match_top #(
	parameter int PATTERN_MAX = wrm_pkg::PATTERN_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [wrm_pkg::CHAR_W-1:0]    text_char,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          matched,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wrm_pkg::WORD_W-1:0]    cfg_data
);
	import wrm_pkg::*;

	// Slots beyond the character registers never get a pattern character.
	localparam int SLOTS = (PATTERN_MAX < CHAR_SLOTS) ? PATTERN_MAX : CHAR_SLOTS;
	localparam int SEL_W = $clog2(SLOTS + 1);

	// Configuration registers
	logic [LEN_W-1:0]  pattern_length_q;
	logic [WORD_W-1:0] chars_low_q;
	logic [WORD_W-1:0] chars_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			chars_low_q      <= '0;
			chars_high_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				CFG_CHARS_LOW:      chars_low_q      <= cfg_data;
				CFG_CHARS_HIGH:     chars_high_q     <= cfg_data;
				default:            ;  // unmapped index: write dropped
			endcase
		end
	end

	// Unpack pattern characters, character 0 in the low byte of the low word.
	logic [CHAR_W-1:0] pchar [CHAR_SLOTS];

	for (genvar k = 0; k < CHAR_SLOTS; k++) begin : g_pchar
		if (k < 8) begin : g_lo
			assign pchar[k] = chars_low_q[CHAR_W*k +: CHAR_W];
		end else begin : g_hi
			assign pchar[k] = chars_high_q[CHAR_W*(k-8) +: CHAR_W];
		end
	end

	// Handshake: result register frees when empty or being drained, so a new
	// item goes in every cycle the consumer keeps up.
	logic  in_fire;
	step_t step;

	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign step.en   = in_fire;
	assign step.load = (mode == MODE_START);
	assign step.ch   = text_char;

	// Column: bit 0 is the empty-pattern prefix, cells 1..SLOTS the rest.
	logic [SLOTS:0] col;
	logic [SLOTS:0] nxt_col;
	logic           col0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q <= 1'b0;
		end else if (step.en) begin
			col0_q <= step.load;  // empty text matches the empty pattern only
		end
	end

	assign col[0]     = col0_q;
	assign nxt_col[0] = step.load;

	for (genvar g = 1; g <= SLOTS; g++) begin : g_cell
		logic back2;
		if (g >= 2) begin : g_b2
			assign back2 = nxt_col[g-2];
		end else begin : g_b1
			assign back2 = 1'b0;
		end

		wrm_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.p_cur     (pchar[g-1]),
			.p_prev    (pchar[(g >= 2) ? g-2 : 0]),
			.old_prev  (col[g-1]),
			.nxt_back2 (back2),
			.col_q     (col[g]),
			.nxt       (nxt_col[g])
		);
	end

	// Length saturates at the number of usable slots.
	logic [SEL_W-1:0] len_sel;

	always_comb begin
		if (pattern_length_q > LEN_W'(SLOTS)) begin
			len_sel = SEL_W'(SLOTS);
		end else begin
			len_sel = pattern_length_q[SEL_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			matched   <= 1'b0;
		end else begin
			if (in_fire) begin
				out_valid <= 1'b1;
				matched   <= nxt_col[len_sel];
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

### design/wrm_checker.sv
// Port-level checker for the matcher, with its bind to the top level.
// Depends on wrm_pkg and wildcard_regex_stream_match_top.
module wrm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          mode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          matched,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [wrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [wrm_pkg::WORD_W-1:0]    cfg_data
);
	import wrm_pkg::*;

	// Shadow of the length register, seen through the write port.
	logic len_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_zero_q <= 1'b1;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_PATTERN_LENGTH) begin
			len_zero_q <= (cfg_data[LEN_W-1:0] == '0);
		end
	end

	// Each accepted transaction yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted item");

	// Input is never blocked while the result register is empty.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Empty pattern: only the empty text matches.
	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && len_zero_q |=> matched == ($past(mode) == MODE_START))
		else $error("wrong result for empty pattern");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched))
		else $error("result changed while stalled");

endmodule

bind wildcard_regex_stream_match_top wrm_checker u_wrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.matched   (matched),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

### test/wrm_match_checker.sv
// Checker for the wildcard pattern stream matcher: watches the item, result and register channels.
// Keeps its own copy of the registers and the prefix column, predicts matched and compares.
// Depends on wrm_pkg.
module wrm_match_checker #(
	parameter int PATTERN_MAX = wrm_pkg::PATTERN_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          mode,
	input  logic [wrm_pkg::CHAR_W-1:0]    text_char,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          matched,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [wrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wrm_pkg::WORD_W-1:0]    cfg_data,
	output int                            failures,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import wrm_pkg::*;

	localparam int USABLE = (PATTERN_MAX < CHAR_SLOTS) ? PATTERN_MAX : CHAR_SLOTS;

	logic [PATTERN_MAX:0] prefix_col;
	logic [LEN_W-1:0]     pat_len;
	logic [WORD_W-1:0]    chars_lo;
	logic [WORD_W-1:0]    chars_hi;
	logic                 match_q[$];
	logic                 want;

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	function automatic logic [CHAR_W-1:0] pat_byte(int pos);
		if (pos < 8)
			return chars_lo[8*pos +: 8];
		if (pos < 16)
			return chars_hi[8*(pos-8) +: 8];
		return '0;
	endfunction

	function automatic logic accepts(logic [CHAR_W-1:0] pc, logic [CHAR_W-1:0] c);
		return (pc == DOT_CODE) || (pc == c);
	endfunction

	// Updates the prefix column for one item, returns the whole-pattern bit.
	function automatic logic match_after_item(logic m, logic [CHAR_W-1:0] c);
		logic [PATTERN_MAX:0] nxt;
		int                   len;
		nxt = '0;
		if (m == MODE_START) begin
			nxt[0] = 1'b1;
			for (int i = 1; i <= USABLE; i++)
				if (pat_byte(i-1) == STAR_CODE && i >= 2)
					nxt[i] = nxt[i-2];
		end else begin
			for (int i = 1; i <= USABLE; i++) begin
				if (pat_byte(i-1) == STAR_CODE) begin
					if (i >= 2)
						nxt[i] = nxt[i-2] || (prefix_col[i] && accepts(pat_byte(i-2), c));
				end else begin
					nxt[i] = prefix_col[i-1] && accepts(pat_byte(i-1), c);
				end
			end
		end
		prefix_col = nxt;
		len = (int'(pat_len) > USABLE) ? USABLE : int'(pat_len);
		return prefix_col[len];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_col = '0;
			pat_len    = '0;
			chars_lo   = '0;
			chars_hi   = '0;
			match_q.delete();
			outstanding = 0;
		end else begin
			// result first: it belongs to a transaction from an earlier edge
			if (out_valid && out_ready) begin
				if (match_q.size() == 0) begin
					$error("matched: expected nothing, actual %0b", matched);
					failures++;
				end else begin
					want = match_q.pop_front();
					if (matched !== want) begin
						$error("matched: expected %0b, actual %0b", want, matched);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LENGTH: pat_len  = cfg_data[LEN_W-1:0];
					CFG_CHARS_LOW:      chars_lo = cfg_data;
					CFG_CHARS_HIGH:     chars_hi = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				match_q.push_back(match_after_item(mode, text_char));
			outstanding = match_q.size();
		end
	end

endmodule

### test/tb_top.sv
// Top of the matcher testbench: clock, reset, stimulus and the final verdict.
// Drives items and register writes into wildcard_regex_stream_match_top; wrm_match_checker
// does the prediction. Depends on wrm_pkg, the block and the checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wrm_pkg::*;

	localparam int                   CYCLE_LIMIT  = 400_000;
	localparam int                   PHASES       = 40;
	localparam int                   PHASE_ITEMS  = 40;
	localparam int                   CALM_PHASES  = 6;   // last phases run without idling
	// index 3 maps to no register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [CHAR_W-1:0]    text_char;
	logic                 out_valid;
	logic                 out_ready;
	logic                 matched;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	int failures;
	int outstanding;
	int cycles = 0;
	int idle_pct = 0;      // idle burst % chance per output cycle, doubled per input item
	int items_sent = 0;

	// pattern as programmed by the stimulus, used only to shape texts that can match
	logic [CHAR_W-1:0] pat_bytes[CHAR_SLOTS];
	int                pat_len_sel;
	logic [CHAR_W-1:0] text_q[$];

	wildcard_regex_stream_match_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.text_char (text_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wrm_match_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.text_char   (text_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.matched     (matched),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side backpressure. One assignment per falling edge: a stall burst lowers
	// ready, and ready only comes back at the edge that ends the burst.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if ($urandom_range(1, 100) <= idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// One item transaction. Entered and left on a falling edge; valid is left high so
	// that back-to-back items never lower and raise it in the same step.
	task automatic send_item(logic m, logic [CHAR_W-1:0] ch);
		int gap;
		gap = ($urandom_range(1, 100) <= 2 * idle_pct) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			// junk payload while valid is low must be ignored
			in_valid  <= 1'b0;
			mode      <= 1'($urandom);
			text_char <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		text_char <= ch;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop sending and wait until every predicted result has been taken.
	// Each item yields exactly one result, registered as the item is accepted, so
	// an empty scoreboard means the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pack_chars(int base);
		logic [WORD_W-1:0] w;
		for (int k = 0; k < 8; k++)
			w[8*k +: 8] = pat_bytes[base + k];
		return w;
	endfunction

	// Writes the chosen registers back to back, then drops cfg_valid once.
	// Upper bits of the length word are random: only the low five count.
	task automatic program_pattern(int len, bit wr_len, bit wr_lo, bit wr_hi);
		logic [WORD_W-1:0] d;
		d = {$urandom, $urandom};
		d[LEN_W-1:0] = LEN_W'(len);
		pat_len_sel = len;
		if (wr_len)
			write_reg(CFG_PATTERN_LENGTH, d);
		if (wr_lo)
			write_reg(CFG_CHARS_LOW, pack_chars(0));
		if (wr_hi)
			write_reg(CFG_CHARS_HIGH, pack_chars(8));
		if (wr_len || wr_lo || wr_hi)
			cfg_valid <= 1'b0;
	endtask

	// Fills pattern slots from a string; slots past it get random bytes.
	function automatic void set_pattern(string s);
		for (int k = 0; k < CHAR_SLOTS; k++)
			pat_bytes[k] = (k < s.len()) ? s[k] : 8'($urandom);
	endfunction

	function automatic logic [CHAR_W-1:0] random_pat_char();
		int r;
		r = $urandom_range(0, 19);
		if (r <= 5)  return "a";
		if (r <= 8)  return "b";
		if (r <= 11) return DOT_CODE;
		if (r <= 15) return STAR_CODE;
		if (r == 16) return 8'h00;
		if (r == 17) return 8'hFF;
		return 8'($urandom);
	endfunction

	// Walks the pattern and emits a text it would accept: a starred element is
	// repeated 0..3 times, a dot becomes any byte. Then a quarter of the texts are
	// broken by one substituted or appended character so that near misses show up too.
	task automatic build_text();
		int                eff;
		int                i;
		int                reps;
		logic [CHAR_W-1:0] e;
		text_q.delete();
		eff = (pat_len_sel > CHAR_SLOTS) ? CHAR_SLOTS : pat_len_sel;
		i = 0;
		while (i < eff && text_q.size() < 24) begin
			e = pat_bytes[i];
			if (i + 1 < eff && pat_bytes[i+1] == STAR_CODE) begin
				reps = $urandom_range(0, 3);
				repeat (reps)
					text_q.push_back((e == DOT_CODE) ? 8'($urandom) : e);
				i += 2;
			end else if (e == STAR_CODE && i == 0) begin
				i++;    // leading star can never be satisfied; skip it
			end else begin
				text_q.push_back((e == DOT_CODE) ? 8'($urandom) : e);
				i++;
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			if (text_q.size() > 0 && $urandom_range(0, 1) == 0)
				text_q[$urandom_range(0, text_q.size() - 1)] = random_pat_char();
			else
				text_q.push_back(random_pat_char());
		end
	endtask

	initial begin
		int  target;
		int  len;
		bit  start_text;
		in_valid  = 1'b0;
		mode      = MODE_START;
		text_char = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PATTERN_LENGTH;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// No text started yet: column is clear, characters keep it clear.
		send_item(MODE_APPEND, 8'hFF);
		send_item(MODE_APPEND, 8'h00);
		// Empty pattern: empty text matches, one character does not.
		send_item(MODE_START, 8'hA5);
		send_item(MODE_APPEND, "a");

		// Write to the unmapped index, then a plain star/dot mix.
		drain();
		write_reg(CFG_UNMAPPED, {$urandom, $urandom});
		set_pattern("a*.b");
		program_pattern(4, 1, 1, 1);
		send_item(MODE_START, 8'h5A);
		send_item(MODE_APPEND, "a");
		send_item(MODE_APPEND, "a");
		send_item(MODE_APPEND, 8'hFF);
		send_item(MODE_APPEND, "b");

		// Leading star: nothing depending on it can match.
		drain();
		set_pattern("*a");
		program_pattern(2, 1, 1, 0);
		send_item(MODE_START, 8'h00);
		send_item(MODE_APPEND, "a");

		// Star after star: the first star is a literal element.
		drain();
		set_pattern("a**");
		program_pattern(3, 1, 1, 0);
		send_item(MODE_START, 8'hFF);
		send_item(MODE_APPEND, "a");
		send_item(MODE_APPEND, STAR_CODE);

		// All 16 slots, a zero byte as the last literal, and a length of 31 that
		// has to saturate to 16.
		drain();
		set_pattern(".*.*.*.*.*.*.*.");
		pat_bytes[15] = 8'h00;
		program_pattern(31, 1, 1, 1);
		send_item(MODE_START, 8'h00);
		send_item(MODE_APPEND, 8'hFF);
		send_item(MODE_APPEND, 8'h00);

		// ---- random part ----
		// Each phase waits for the block to go idle (the sender holds off until every
		// result is back), reprograms some or all registers and streams texts built
		// from the pattern. Now and then the old text carries on across the register
		// change, and some items are pure noise.
		target = items_sent;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph >= PHASES - CALM_PHASES || ph % 7 == 3)
				idle_pct = 0;
			else
				idle_pct = 8;
			drain();
			case ($urandom_range(0, 19))
				0:       len = 0;
				1:       len = CHAR_SLOTS;
				2:       len = $urandom_range(CHAR_SLOTS + 1, 31);
				default: len = $urandom_range(1, 12);
			endcase
			for (int k = 0; k < CHAR_SLOTS; k++)
				pat_bytes[k] = random_pat_char();
			if (ph == 0)
				program_pattern(len, 1, 1, 1);
			else
				program_pattern(len, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
					$urandom_range(0, 2) != 0);
			start_text = ($urandom_range(0, 4) != 0);
			target += PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(1'($urandom), 8'($urandom));
				end else begin
					build_text();
					if (start_text)
						send_item(MODE_START, 8'($urandom));
					foreach (text_q[k])
						send_item(MODE_APPEND, text_q[k]);
					start_text = 1'b1;
				end
			end
		end

		// ---- wrap up ----
		drain();
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
